>>> src/bapd_pkg.sv
`default_nettype none
package bapd_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int BLOCK_LOG2    = 5;
  localparam int BLOCK_SAMPLES = 1 << BLOCK_LOG2;
  localparam int SUM_W         = SAMPLE_W + BLOCK_LOG2;
  localparam int CNT_W         = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;

  localparam int WINDOW_DEPTH  = 8;
  localparam int POS_W         = $clog2(WINDOW_DEPTH);
  localparam int MISS_W        = $clog2(WINDOW_DEPTH + 1);

  localparam int ALLOWED_W     = 4;
  localparam int CMP_W         = (MISS_W > ALLOWED_W) ? MISS_W : ALLOWED_W;
  localparam int CFG_W         = SAMPLE_W;
  localparam int CFG_IDX_W     = 2;

  localparam logic [SAMPLE_W-1:0]  THRESH_RESET  = 12'd1000;
  localparam logic [ALLOWED_W-1:0] ALLOWED_RESET = 4'd1;

  localparam int FIFO_DEPTH    = 2;
  localparam int FIFO_AW       = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW       = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_ALLOWED   = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] voltage_mean;
    logic [SAMPLE_W-1:0] detect_mean;
  } mean_pair_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage
`default_nettype wire

>>> src/block_average_presence_detector_top.sv
// with no output stall a result passes from the two-entry mean queue into the output
// registers once the edge that takes the last pair of its block has written it to the queue
// throughput: one sample pair per cycle while in_stall is low, one result per 32 pairs
// in_stall rises only when the two-entry mean queue is full behind a stalled output
// reset (rst, synchronous, active high) clears sums, pair count, detect window and queue,
// and sets the presence threshold to 1000 and allowed_misses to 1
`default_nettype none
module block_average_presence_detector_top import bapd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [SAMPLE_W-1:0]  voltage_sample,
  input  wire logic [SAMPLE_W-1:0]  detect_sample,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SAMPLE_W-1:0]       voltage_mean,
  output logic [SAMPLE_W-1:0]       detect_mean,
  output logic                      detected,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [SAMPLE_W-1:0]  presence_threshold;
  logic [ALLOWED_W-1:0] allowed_misses;
  fifo_stat_t           q_stat;
  mean_pair_t           push_data, pop_data;
  logic                 push, pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      presence_threshold <= THRESH_RESET;
      allowed_misses     <= ALLOWED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: presence_threshold <= cfg_data[SAMPLE_W-1:0];
        REG_ALLOWED:   allowed_misses     <= cfg_data[ALLOWED_W-1:0];
        default: ;
      endcase
    end
  end

  bapd_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .voltage_sample (voltage_sample),
    .detect_sample  (detect_sample),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  bapd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  bapd_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_stat             (q_stat),
    .q_data             (pop_data),
    .pop                (pop),
    .presence_threshold (presence_threshold),
    .allowed_misses     (allowed_misses),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .voltage_mean       (voltage_mean),
    .detect_mean        (detect_mean),
    .detected           (detected)
  );

endmodule
`default_nettype wire

>>> src/bapd_front.sv
`default_nettype none
module bapd_front import bapd_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [SAMPLE_W-1:0] voltage_sample,
  input  wire logic [SAMPLE_W-1:0] detect_sample,
  input  wire fifo_stat_t          q_stat,
  output logic                     push,
  output mean_pair_t               push_data
);

  logic [SUM_W-1:0] voltage_sum, voltage_sum_next;
  logic [SUM_W-1:0] detect_sum, detect_sum_next;
  logic [CNT_W-1:0] block_count;
  logic             accept, last;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !in_stall;
  assign last     = (block_count == CNT_W'(BLOCK_SAMPLES - 1));
  assign push     = accept && last;

  assign voltage_sum_next = voltage_sum + SUM_W'(voltage_sample);
  assign detect_sum_next  = detect_sum + SUM_W'(detect_sample);

  // power-of-two block, so the mean is the upper bits
  assign push_data.voltage_mean = voltage_sum_next[SUM_W-1:BLOCK_LOG2];
  assign push_data.detect_mean  = detect_sum_next[SUM_W-1:BLOCK_LOG2];

  always_ff @(posedge clk) begin
    if (rst) begin
      voltage_sum <= '0;
      detect_sum  <= '0;
      block_count <= '0;
    end else if (accept) begin
      if (last) begin
        voltage_sum <= '0;
        detect_sum  <= '0;
        block_count <= '0;
      end else begin
        voltage_sum <= voltage_sum_next;
        detect_sum  <= detect_sum_next;
        block_count <= block_count + CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bapd_fifo.sv
`default_nettype none
module bapd_fifo import bapd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mean_pair_t push_data,
  input  wire logic       pop,
  output mean_pair_t      pop_data,
  output fifo_stat_t      stat
);

  mean_pair_t           entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_push, do_pop;

  assign stat.full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + FIFO_CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - FIFO_CW'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> src/bapd_back.sv
`default_nettype none
module bapd_back import bapd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fifo_stat_t           q_stat,
  input  wire mean_pair_t           q_data,
  output logic                      pop,
  input  wire logic [SAMPLE_W-1:0]  presence_threshold,
  input  wire logic [ALLOWED_W-1:0] allowed_misses,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [SAMPLE_W-1:0]       voltage_mean,
  output logic [SAMPLE_W-1:0]       detect_mean,
  output logic                      detected
);

  logic [SAMPLE_W-1:0] detect_window [WINDOW_DEPTH];
  logic [POS_W-1:0]    window_position;
  logic [MISS_W-1:0]   miss_count;
  logic                detected_next;

  assign pop = !q_stat.empty && (!out_valid || !out_stall);

  // misses over the window as it stands after this write
  always_comb begin
    miss_count = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (POS_W'(i) == window_position) begin
        if (q_data.detect_mean <= presence_threshold) begin
          miss_count = miss_count + MISS_W'(1);
        end
      end else if (detect_window[i] <= presence_threshold) begin
        miss_count = miss_count + MISS_W'(1);
      end
    end
  end

  assign detected_next = (CMP_W'(miss_count) <= CMP_W'(allowed_misses));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_DEPTH; i++) begin
        detect_window[i] <= '0;
      end
      window_position <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (pop) begin
        detect_window[window_position] <= q_data.detect_mean;
        if (window_position == POS_W'(WINDOW_DEPTH - 1)) begin
          window_position <= '0;
        end else begin
          window_position <= window_position + POS_W'(1);
        end
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      voltage_mean <= q_data.voltage_mean;
      detect_mean  <= q_data.detect_mean;
      detected     <= detected_next;
    end
  end

endmodule
`default_nettype wire

>>> src/bapd_checker.sv
`default_nettype none
module bapd_checker import bapd_pkg::*; (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 in_stall,
  input wire logic                 out_valid,
  input wire logic                 out_stall,
  input wire logic [SAMPLE_W-1:0]  voltage_mean,
  input wire logic [SAMPLE_W-1:0]  detect_mean,
  input wire logic                 detected
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(voltage_mean) && $stable(detect_mean)
      && $stable(detected))
    else $error("stalled result changed");

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> !in_stall)
    else $error("input stalled right after reset");

  // the queue only fills behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst) in_stall |-> out_valid)
    else $error("input stalled with no result pending");

endmodule

bind block_average_presence_detector_top bapd_checker u_chk (.*);
`default_nettype wire

>>> sim/bapd_mean_checker.sv
module bapd_mean_checker import bapd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_stall,
  input  wire logic [SAMPLE_W-1:0]  voltage_sample,
  input  wire logic [SAMPLE_W-1:0]  detect_sample,
  input  wire logic                 out_valid,
  input  wire logic                 out_stall,
  input  wire logic [SAMPLE_W-1:0]  voltage_mean,
  input  wire logic [SAMPLE_W-1:0]  detect_mean,
  input  wire logic                 detected,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output int                        mismatch_count,
  output int                        pending_means,
  output int                        means_checked,
  output int                        pairs_taken
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SAMPLE_W-1:0] voltage_mean;
    logic [SAMPLE_W-1:0] detect_mean;
    logic                detected;
  } block_mean_t;

  block_mean_t          mean_queue[$];
  logic [SAMPLE_W-1:0]  threshold;
  logic [ALLOWED_W-1:0] allowed;
  int unsigned          voltage_acc;
  int unsigned          detect_acc;
  int                   pair_cnt;
  logic [SAMPLE_W-1:0]  history [WINDOW_DEPTH];
  int                   history_pos;
  int                   fails = 0;
  int                   seen = 0;
  int                   pairs = 0;

  initial begin
    mismatch_count = 0;
    pending_means  = 0;
    means_checked  = 0;
    pairs_taken    = 0;
  end

  // closes the current block: means, window update and presence decision
  function automatic block_mean_t close_block();
    block_mean_t m;
    int          misses;
    m.voltage_mean = SAMPLE_W'(voltage_acc / BLOCK_SAMPLES);
    m.detect_mean  = SAMPLE_W'(detect_acc / BLOCK_SAMPLES);
    voltage_acc = 0;
    detect_acc  = 0;
    pair_cnt    = 0;
    history[history_pos] = m.detect_mean;
    history_pos = (history_pos + 1) % WINDOW_DEPTH;
    misses = 0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      if (history[i] <= threshold) misses++;
    end
    m.detected = (misses <= int'(allowed));
    return m;
  endfunction

  always @(posedge clk) begin
    block_mean_t want;
    if (rst) begin
      mean_queue.delete();
      threshold   = THRESH_RESET;
      allowed     = ALLOWED_RESET;
      voltage_acc = 0;
      detect_acc  = 0;
      pair_cnt    = 0;
      history_pos = 0;
      for (int i = 0; i < WINDOW_DEPTH; i++) history[i] = '0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mean_queue.size() == 0) begin
          $error("unexpected result transaction: voltage_mean %0d detect_mean %0d detected %0d",
                 voltage_mean, detect_mean, detected);
          fails++;
        end else begin
          want = mean_queue.pop_front();
          seen++;
          if (voltage_mean !== want.voltage_mean) begin
            $error("voltage_mean: expected %0d, actual %0d", want.voltage_mean, voltage_mean);
            fails++;
          end
          if (detect_mean !== want.detect_mean) begin
            $error("detect_mean: expected %0d, actual %0d", want.detect_mean, detect_mean);
            fails++;
          end
          if (detected !== want.detected) begin
            $error("detected: expected %0d, actual %0d", want.detected, detected);
            fails++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_index == REG_THRESHOLD) threshold = cfg_data[SAMPLE_W-1:0];
        else if (cfg_index == REG_ALLOWED) allowed = cfg_data[ALLOWED_W-1:0];
      end
      if (in_valid && !in_stall) begin
        pairs++;
        voltage_acc += voltage_sample;
        detect_acc  += detect_sample;
        pair_cnt++;
        if (pair_cnt == BLOCK_SAMPLES) mean_queue.push_back(close_block());
      end
    end
    mismatch_count <= fails;
    pending_means  <= mean_queue.size();
    means_checked  <= seen;
    pairs_taken    <= pairs;
  end

endmodule

>>> sim/block_average_presence_detector_top_tb.sv
module block_average_presence_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bapd_pkg::*;

  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 300;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef enum int {MODE_NOISE, MODE_FLAT, MODE_JITTER} level_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  voltage_sample = '0;
  logic [SAMPLE_W-1:0]  detect_sample = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  voltage_mean;
  logic [SAMPLE_W-1:0]  detect_mean;
  logic                 detected;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  int mismatch_count;
  int pending_means;
  int means_checked;
  int pairs_taken;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_trigger = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pairs_offered = 0;
  int settings_done = 0;
  int cycle_count = 0;
  logic [SAMPLE_W-1:0] cur_threshold = THRESH_RESET;

  always #5 clk = ~clk;

  block_average_presence_detector_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .voltage_sample (voltage_sample),
    .detect_sample  (detect_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voltage_mean   (voltage_mean),
    .detect_mean    (detect_mean),
    .detected       (detected),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  bapd_mean_checker u_mean_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .voltage_sample (voltage_sample),
    .detect_sample  (detect_sample),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .voltage_mean   (voltage_mean),
    .detect_mean    (detect_mean),
    .detected       (detected),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_means  (pending_means),
    .means_checked  (means_checked),
    .pairs_taken    (pairs_taken)
  );

  // output side: random stalls plus an occasional long hold
  always @(posedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int x);
    if (x < 0) return '0;
    if (x > SAMPLE_MAX) return SAMPLE_W'(SAMPLE_MAX);
    return SAMPLE_W'(x);
  endfunction

  task automatic offer_pair(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    voltage_sample <= v;
    detect_sample  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pairs_offered++;
  endtask

  task automatic offer_block(input logic [SAMPLE_W-1:0] v, input logic [SAMPLE_W-1:0] d);
    repeat (BLOCK_SAMPLES) offer_pair(v, d);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_means != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_detector(input logic [CFG_W-1:0] thr_word,
                                  input logic [CFG_W-1:0] allowed_word);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= thr_word;
    @(posedge clk);
    cfg_index <= REG_ALLOWED;
    cfg_data  <= allowed_word;
    @(posedge clk);
    cfg_index <= REG_SPARE_LO;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_index <= REG_SPARE_HI;
    cfg_data  <= CFG_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_threshold = thr_word[SAMPLE_W-1:0];
    settings_done++;
  endtask

  // each block picks its own detect mode and level so the window sees hits and misses
  task automatic stream_pairs(input int count);
    level_mode_t         mode;
    int                  level;
    logic [SAMPLE_W-1:0] v;
    logic [SAMPLE_W-1:0] d;
    mode  = MODE_NOISE;
    level = 0;
    repeat (count) begin
      if (pairs_offered % BLOCK_SAMPLES == 0) begin
        mode = level_mode_t'($urandom_range(2));
        if (mode == MODE_FLAT) level = int'(cur_threshold) + $urandom_range(2) - 1;
        else if ($urandom_range(1)) level = int'(cur_threshold) + $urandom_range(400) - 200;
        else level = $urandom_range(SAMPLE_MAX);
      end
      v = SAMPLE_W'($urandom);
      case (mode)
        MODE_NOISE: d = SAMPLE_W'($urandom);
        MODE_FLAT: d = clamp_sample(level);
        default: begin
          d = clamp_sample(level + $urandom_range(30) - 15);
          v = clamp_sample(level + $urandom_range(60) - 30);
        end
      endcase
      offer_pair(v, d);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // extremes, a start-up window of zeros, and a mean equal to the threshold
    offer_block(SAMPLE_W'(SAMPLE_MAX), '0);
    offer_block('0, SAMPLE_W'(SAMPLE_MAX));
    offer_block(SAMPLE_W'(SAMPLE_MAX), cur_threshold);

    // long output hold while input keeps coming
    hold_trigger <= hold_trigger + 1;
    stream_pairs(304);

    program_detector(12'd0, 12'd0);
    send_idle_pct = 71;
    stall_pct     = 0;
    stream_pairs(250);

    // upper bits of the allowance word must be dropped
    program_detector(12'd4095, 12'hFF8);
    send_idle_pct = 0;
    stall_pct     = 71;
    stream_pairs(250);

    program_detector(12'd2048, 12'hFFF);
    send_idle_pct = 14;
    stall_pct     = 14;
    stream_pairs(250);

    program_detector(12'd1500, 12'd3);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_trigger <= hold_trigger + 1;
    stream_pairs(250);

    settle();
    $display("%0d sample pairs taken, %0d block results checked", pairs_taken, means_checked);
    $display("%0d register settings after reset, idle and stall mixes, two long output holds",
             settings_done);
    if (mismatch_count == 0 && pending_means == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bapd_pkg.sv
src/bapd_front.sv
src/bapd_fifo.sv
src/bapd_back.sv
src/block_average_presence_detector_top.sv
src/bapd_checker.sv
sim/bapd_mean_checker.sv
sim/block_average_presence_detector_top_tb.sv
